[hw/rtl/ray_sphere_intersect_unit_macros.svh]
// assertion macros for the ray-sphere intersection unit
`ifndef RAY_SPHERE_INTERSECT_UNIT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RSI_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RSI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RSI_ASSERT(lbl, cond, msg)
`define RSI_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[hw/rtl/rsi_pkg.sv]
// widths and carried-state types for the ray-sphere intersection unit
package rsi_pkg;
  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int RW   = CW - 1;
  localparam int VW   = CW + 1;
  localparam int PW   = 2 * CW + 6;
  localparam int QW   = PW - FB;
  localparam int MW   = QW - 1;
  localparam int HLW  = (MW + 1) / 2;
  localparam int HHW  = MW - HLW;
  localparam int PPW  = 2 * HLW;
  localparam int SW   = MW + 1;
  localparam int DUW  = 2 * SW;
  localparam int RMW  = SW + 2;
  localparam int NW   = QW + 2;
  localparam int NUW  = NW - 1;
  localparam int XW   = MW + CW + FB;
  localparam int DQW  = CW - 1;

  typedef struct packed {
    logic                 kill;
    logic signed [QW-1:0] hq;
    logic [MW-1:0]        am;
  } sq_carry_t;

  typedef struct packed {
    logic          kill;
    logic          hit;
    logic          sat;
    logic [MW-1:0] am;
  } dv_carry_t;
endpackage

[hw/rtl/ray_sphere_intersect_unit.sv]
// ray-sphere intersection: fully pipelined quadratic, square root and divide
// throughput one item per cycle; the whole pipe stalls together on output backpressure
// stage depth is set by one bit per stage in the square root and divider pipes
// synchronous active-low reset clears all valid bits; payload registers are not reset
`include "ray_sphere_intersect_unit_macros.svh"
module ray_sphere_intersect_unit import rsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_origin_x,
  input  logic signed [31:0]   in_origin_y,
  input  logic signed [31:0]   in_origin_z,
  input  logic signed [31:0]   in_dir_x,
  input  logic signed [31:0]   in_dir_y,
  input  logic signed [31:0]   in_dir_z,
  input  logic signed [31:0]   in_center_x,
  input  logic signed [31:0]   in_center_y,
  input  logic signed [31:0]   in_center_z,
  input  logic [30:0]          in_radius,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_root_found,
  output logic [30:0]          out_distance
);

  logic en;
  logic o_vld_r;
  assign en       = !o_vld_r || out_ready;
  assign in_ready = en;

  // stage 1: v = origin - centre
  logic signed [CW-1:0] o_a [3];
  logic signed [CW-1:0] d_a [3];
  logic signed [CW-1:0] c_a [3];
  logic                 s1_vld_r;
  logic signed [VW-1:0] s1_v_r [3];
  logic signed [CW-1:0] s1_d_r [3];
  logic [RW-1:0]        s1_r_r;

  assign o_a[0] = in_origin_x[CW-1:0];
  assign o_a[1] = in_origin_y[CW-1:0];
  assign o_a[2] = in_origin_z[CW-1:0];
  assign d_a[0] = in_dir_x[CW-1:0];
  assign d_a[1] = in_dir_y[CW-1:0];
  assign d_a[2] = in_dir_z[CW-1:0];
  assign c_a[0] = in_center_x[CW-1:0];
  assign c_a[1] = in_center_y[CW-1:0];
  assign c_a[2] = in_center_z[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_v_r[i] <= VW'(o_a[i]) - VW'(c_a[i]);
        s1_d_r[i] <= d_a[i];
      end
      s1_r_r <= in_radius[RW-1:0];
    end
  end

  // stage 2: products
  logic                      s2_vld_r;
  logic signed [2*CW-1:0]    s2_dd_r [3];
  logic signed [CW+VW-1:0]   s2_dv_r [3];
  logic signed [2*VW-1:0]    s2_vv_r [3];
  logic [2*RW-1:0]           s2_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd_r[i] <= (2*CW)'(s1_d_r[i]) * (2*CW)'(s1_d_r[i]);
        s2_dv_r[i] <= (CW+VW)'(s1_d_r[i]) * (CW+VW)'(s1_v_r[i]);
        s2_vv_r[i] <= (2*VW)'(s1_v_r[i]) * (2*VW)'(s1_v_r[i]);
      end
      s2_rr_r <= (2*RW)'(s1_r_r) * (2*RW)'(s1_r_r);
    end
  end

  // stage 3: sums, floored to the fixed-point scale
  logic signed [PW-1:0] aw, hw, cw;
  logic                 s3_vld_r;
  logic signed [QW-1:0] s3_aq_r, s3_hq_r, s3_cq_r;

  always_comb begin
    aw = PW'(s2_dd_r[0]) + PW'(s2_dd_r[1]) + PW'(s2_dd_r[2]);
    hw = PW'(s2_dv_r[0]) + PW'(s2_dv_r[1]) + PW'(s2_dv_r[2]);
    cw = PW'(s2_vv_r[0]) + PW'(s2_vv_r[1]) + PW'(s2_vv_r[2])
       - $signed({{(PW-2*RW){1'b0}}, s2_rr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_aq_r <= aw[PW-1:FB];
      s3_hq_r <= hw[PW-1:FB];
      s3_cq_r <= cw[PW-1:FB];
    end
  end

  // stage 4: magnitudes and zero-direction check
  logic signed [QW-1:0] habs, cabs;
  logic                 s4_vld_r;
  logic                 s4_kill_r;
  logic                 s4_cneg_r;
  logic signed [QW-1:0] s4_hq_r;
  logic [MW-1:0]        s4_hm_r, s4_am_r, s4_cm_r;

  assign habs = s3_hq_r[QW-1] ? -s3_hq_r : s3_hq_r;
  assign cabs = s3_cq_r[QW-1] ? -s3_cq_r : s3_cq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_kill_r <= s3_aq_r[QW-1] || (s3_aq_r == '0);
      s4_cneg_r <= s3_cq_r[QW-1];
      s4_hq_r   <= s3_hq_r;
      s4_hm_r   <= habs[MW-1:0];
      s4_am_r   <= s3_aq_r[MW-1:0];
      s4_cm_r   <= cabs[MW-1:0];
    end
  end

  // stage 5: partial products of h*h and a*c
  logic [HLW-1:0] h0, a0, c0;
  logic [HLW-1:0] h1, a1, c1;
  logic           s5_vld_r;
  sq_carry_t      s5_cy_r;
  logic           s5_cneg_r;
  logic [PPW-1:0] s5_h00_r, s5_h01_r, s5_h11_r;
  logic [PPW-1:0] s5_a00_r, s5_a01_r, s5_a10_r, s5_a11_r;

  assign h0 = s4_hm_r[HLW-1:0];
  assign a0 = s4_am_r[HLW-1:0];
  assign c0 = s4_cm_r[HLW-1:0];
  assign h1 = HLW'(s4_hm_r[MW-1:HLW]);
  assign a1 = HLW'(s4_am_r[MW-1:HLW]);
  assign c1 = HLW'(s4_cm_r[MW-1:HLW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_cy_r   <= '{kill: s4_kill_r, hq: s4_hq_r, am: s4_am_r};
      s5_cneg_r <= s4_cneg_r;
      s5_h00_r  <= PPW'(h0) * PPW'(h0);
      s5_h01_r  <= PPW'(h0) * PPW'(h1);
      s5_h11_r  <= PPW'(h1) * PPW'(h1);
      s5_a00_r  <= PPW'(a0) * PPW'(c0);
      s5_a01_r  <= PPW'(a0) * PPW'(c1);
      s5_a10_r  <= PPW'(a1) * PPW'(c0);
      s5_a11_r  <= PPW'(a1) * PPW'(c1);
    end
  end

  // stage 6: recombine
  logic           s6_vld_r;
  sq_carry_t      s6_cy_r;
  logic           s6_cneg_r;
  logic [DUW-1:0] s6_hh_r, s6_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_cy_r   <= s5_cy_r;
      s6_cneg_r <= s5_cneg_r;
      s6_hh_r   <= DUW'(s5_h00_r) + (DUW'(s5_h01_r) << (HLW + 1))
                 + (DUW'(s5_h11_r) << (2 * HLW));
      s6_ac_r   <= DUW'(s5_a00_r) + ((DUW'(s5_a01_r) + DUW'(s5_a10_r)) << HLW)
                 + (DUW'(s5_a11_r) << (2 * HLW));
    end
  end

  // stage 7: discriminant, then one root bit per stage
  logic            sq_vld_r  [SW+1];
  sq_carry_t       sq_cy_r   [SW+1];
  logic [RMW-1:0]  sq_rem_r  [SW+1];
  logic [SW-1:0]   sq_root_r [SW+1];
  logic [DUW-1:0]  sq_dsh_r  [SW+1];
  logic [DUW-1:0]  disc_nxt;
  logic            disc_neg;

  assign disc_nxt = s6_cneg_r ? (s6_hh_r + s6_ac_r) : (s6_hh_r - s6_ac_r);
  assign disc_neg = !s6_cneg_r && (s6_ac_r > s6_hh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_cy_r[0]      <= '{kill: s6_cy_r.kill || disc_neg, hq: s6_cy_r.hq, am: s6_cy_r.am};
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
      sq_dsh_r[0]     <= disc_nxt;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RMW+1:0] rem_t, trial;
    logic           ge;
    logic [RMW-1:0] rem_nxt;
    logic [SW-1:0]  root_nxt;

    always_comb begin
      rem_t    = {sq_rem_r[k], sq_dsh_r[k][DUW-1:DUW-2]};
      trial    = (RMW+2)'({sq_root_r[k], 2'b01});
      ge       = rem_t >= trial;
      rem_nxt  = ge ? RMW'(rem_t - trial) : RMW'(rem_t);
      root_nxt = {sq_root_r[k][SW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_cy_r[k+1]   <= sq_cy_r[k];
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
        sq_dsh_r[k+1]  <= sq_dsh_r[k] << 2;
      end
    end
  end

  // root numerators and choice
  logic signed [NW-1:0] hq_e, s_e, n1, n2;
  logic                 n_hit, n_found;
  logic                 nm_vld_r;
  dv_carry_t            nm_cy_r;
  logic [NUW-1:0]       nm_num_r;

  always_comb begin
    hq_e    = NW'(sq_cy_r[SW].hq);
    s_e     = $signed(NW'(sq_root_r[SW]));
    n1      = s_e - hq_e;
    n2      = -hq_e - s_e;
    n_hit   = !n2[NW-1] && (n2 != '0);
    n_found = n_hit || (!n1[NW-1] && (n1 != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else if (en) begin
      nm_vld_r <= sq_vld_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_cy_r  <= '{kill: sq_cy_r[SW].kill || !n_found, hit: n_hit, sat: 1'b0,
                    am: sq_cy_r[SW].am};
      nm_num_r <= n_hit ? n2[NUW-1:0] : n1[NUW-1:0];
    end
  end

  // saturation check, then one quotient bit per stage
  logic            dv_vld_r [DQW+1];
  dv_carry_t       dv_cy_r  [DQW+1];
  logic [XW-1:0]   dv_rem_r [DQW+1];
  logic [DQW-1:0]  dv_q_r   [DQW+1];
  logic [XW-1:0]   nsh;

  assign nsh = XW'(nm_num_r) << FB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= nm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_cy_r[0]  <= '{kill: nm_cy_r.kill, hit: nm_cy_r.hit,
                       sat: nsh >= (XW'(nm_cy_r.am) << (CW - 1)), am: nm_cy_r.am};
      dv_rem_r[0] <= nsh;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DQW; j++) begin : g_div
    logic [XW-1:0] cand;
    logic          ge;

    always_comb begin
      cand = XW'(dv_cy_r[j].am) << (DQW - 1 - j);
      ge   = dv_rem_r[j] >= cand;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_cy_r[j+1]  <= dv_cy_r[j];
        dv_rem_r[j+1] <= ge ? (dv_rem_r[j] - cand) : dv_rem_r[j];
        dv_q_r[j+1]   <= {dv_q_r[j][DQW-2:0], ge};
      end
    end
  end

  // output register
  logic           o_hit_r, o_found_r;
  logic [DQW-1:0] o_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= dv_vld_r[DQW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit_r   <= !dv_cy_r[DQW].kill && dv_cy_r[DQW].hit;
      o_found_r <= !dv_cy_r[DQW].kill;
      o_dist_r  <= dv_cy_r[DQW].kill ? '0 : (dv_cy_r[DQW].sat ? '1 : dv_q_r[DQW]);
    end
  end

  assign out_valid      = o_vld_r;
  assign out_hit        = o_hit_r;
  assign out_root_found = o_found_r;
  assign out_distance   = o_dist_r;

  `RSI_ASSERT(a_hit_needs_root, !out_valid || !out_hit || out_root_found, "hit without root")
  `RSI_ASSERT(a_no_root_zero, !out_valid || out_root_found || (out_distance == '0), "stray dist")
  `RSI_ASSERT_NEXT(a_enter, in_valid && in_ready, s1_vld_r, "transfer lost at entry")
  `RSI_ASSERT_NEXT(a_stall_hold, !en, $stable(dv_vld_r[DQW]) && $stable(sq_vld_r[0]), "moved")

endmodule
